### design/lbmv_pkg.sv
// Shared types, constants and helpers for the boundary macro value block.
`timescale 1ns / 1ps
`default_nettype none
package lbmv_pkg;

    localparam int FRAC_BITS = 14;
    localparam int MAX_ROWS  = 1024;
    localparam int Q_BITS    = 17;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 16;
    localparam int HM1_W     = 10;

    localparam logic [2:0] K_EAST  = 3'd0;
    localparam logic [2:0] K_NORTH = 3'd1;
    localparam logic [2:0] K_WEST  = 3'd2;
    localparam logic [2:0] K_SOUTH = 3'd3;
    localparam logic [2:0] K_NE    = 3'd4;
    localparam logic [2:0] K_NW    = 3'd5;
    localparam logic [2:0] K_SW    = 3'd6;
    localparam logic [2:0] K_SE    = 3'd7;

    localparam logic REG_REF_VEL = 1'b0;
    localparam logic REG_HEIGHT  = 1'b1;

    typedef struct packed {
        logic        flag;
        logic [15:0] val;
    } t_sat;

    function automatic t_sat sat16(input logic signed [17:0] v);
        t_sat r;
        if (v > 18'sd32767) begin
            r.flag = 1'b1;
            r.val  = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            r.flag = 1'b1;
            r.val  = 16'h8000;
        end else begin
            r.flag = 1'b0;
            r.val  = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/lbmv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module lbmv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [lbmv_pkg::NUM_W-1:0] i_num,
    input  wire logic [lbmv_pkg::DEN_W-1:0] i_den,
    output logic      [lbmv_pkg::Q_BITS-1:0] o_quo
);
    import lbmv_pkg::*;

    logic [DEN_W-1:0]  r_rem [Q_BITS];
    logic [Q_BITS-1:0] r_low [Q_BITS];
    logic [Q_BITS-1:0] r_quo [Q_BITS];
    logic [DEN_W-1:0]  r_den [Q_BITS];

    genvar k;
    generate
        for (k = 0; k < Q_BITS; k++) begin : g_stage
            logic [DEN_W-1:0]  w_rem;
            logic [Q_BITS-1:0] w_low;
            logic [Q_BITS-1:0] w_quo;
            logic [DEN_W-1:0]  w_den;
            logic [DEN_W:0]    w_trial;
            logic [DEN_W:0]    w_diff;
            logic              w_ge;

            if (k == 0) begin : g_first
                assign w_rem = i_num[NUM_W-2:Q_BITS];
                assign w_low = i_num[Q_BITS-1:0];
                assign w_quo = '0;
                assign w_den = i_den;
            end else begin : g_next
                assign w_rem = r_rem[k-1];
                assign w_low = r_low[k-1];
                assign w_quo = r_quo[k-1];
                assign w_den = r_den[k-1];
            end

            assign w_trial = {w_rem, w_low[Q_BITS-1-k]};
            assign w_ge    = w_trial >= {1'b0, w_den};
            assign w_diff  = w_trial - {1'b0, w_den};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_low[k] <= w_low;
                    r_quo[k] <= {w_quo[Q_BITS-2:0], w_ge};
                    r_den[k] <= w_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[Q_BITS-1];

endmodule
`default_nettype wire

### design/lattice_boundary_macro_values_top.sv
// The result path runs through two 17-stage divider pipelines between the input and output registers.
// Throughput: one item per cycle; the whole pipeline advances unless the output is stalled.
// Each divider retires one quotient bit per stage, so depth, not rate, grows with precision.
// Reset: synchronous active low; clears valid bits and loads the register defaults.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module lattice_boundary_macro_values_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [9:0]  i_row_index,
    input  wire logic signed [15:0] i_slot_0,
    input  wire logic signed [15:0] i_slot_1,
    input  wire logic signed [15:0] i_slot_2,
    input  wire logic signed [15:0] i_slot_3,
    input  wire logic signed [15:0] i_slot_4,
    input  wire logic signed [15:0] i_slot_5,
    input  wire logic signed [15:0] i_slot_6,
    input  wire logic signed [15:0] i_slot_7,
    input  wire logic signed [15:0] i_slot_8,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_velocity_x,
    output logic signed [15:0] o_velocity_y,
    output logic signed [15:0] o_density,
    output logic             o_range_flag
);
    import lbmv_pkg::*;

    typedef struct packed {
        logic                valid;
        logic [2:0]          kind;
        logic                sign;
        logic                ovf;
        logic signed [16:0]  udir;
        logic signed [19:0]  sum;
        logic signed [17:0]  corner;
    } t_side1;

    typedef struct packed {
        logic                valid;
        logic [2:0]          kind;
        logic                sign;
        logic                ovf;
        logic                den_bad;
        logic [15:0]         u;
        logic                flag;
        logic signed [17:0]  corner;
    } t_side2;

    logic signed [15:0] r_ref_vel;
    logic [10:0]        r_height;
    logic               adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_vel <= 16'sd1638;
            r_height  <= 11'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REF_VEL: r_ref_vel <= i_cfg_data;
                REG_HEIGHT:  r_height  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Stage 1: input capture.
    logic               r1_valid;
    logic [2:0]         r1_kind;
    logic [9:0]         r1_y;
    logic signed [15:0] r1_f [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind <= i_req_type;
            r1_y    <= i_row_index;
            r1_f[0] <= i_slot_0;
            r1_f[1] <= i_slot_1;
            r1_f[2] <= i_slot_2;
            r1_f[3] <= i_slot_3;
            r1_f[4] <= i_slot_4;
            r1_f[5] <= i_slot_5;
            r1_f[6] <= i_slot_6;
            r1_f[7] <= i_slot_7;
            r1_f[8] <= i_slot_8;
        end
    end

    // Stage 2: profile product, weighted sums.
    logic [HM1_W-1:0]   s1_hm1;
    logic signed [11:0] s1_t;
    logic signed [27:0] s1_prod;
    logic signed [16:0] s1_udir;
    logic signed [19:0] e [9];
    logic signed [19:0] s1_sum;
    logic signed [17:0] s1_corner;

    always_comb begin
        if (r_height < 11'd2) begin
            s1_hm1 = 10'd1;
        end else if (r_height > 11'(MAX_ROWS)) begin
            s1_hm1 = 10'(MAX_ROWS - 1);
        end else begin
            s1_hm1 = 10'(r_height - 11'd1);
        end
        s1_t    = $signed({1'b0, r1_y, 1'b0}) - $signed({2'b00, s1_hm1});
        s1_prod = r_ref_vel * s1_t;
        if (r1_kind == K_NORTH || r1_kind == K_NE || r1_kind == K_NW) begin
            s1_udir = {r_ref_vel[15], r_ref_vel};
        end else begin
            s1_udir = -{r_ref_vel[15], r_ref_vel};
        end
        for (int i = 0; i < 9; i++) begin
            e[i] = {{4{r1_f[i][15]}}, r1_f[i]};
        end
        case (r1_kind)
            K_EAST:  s1_sum = e[0] + e[2] + e[4] + ((e[1] + e[5] + e[8]) <<< 1);
            K_NORTH: s1_sum = e[0] + e[1] + e[3] + ((e[2] + e[5] + e[6]) <<< 1);
            K_WEST:  s1_sum = e[0] + e[2] + e[4] + ((e[3] + e[6] + e[7]) <<< 1);
            default: s1_sum = e[0] + e[1] + e[3] + ((e[4] + e[7] + e[8]) <<< 1);
        endcase
        s1_corner = e[0][17:0] + e[1][17:0] - e[2][17:0];
    end

    logic               r2_valid;
    logic [2:0]         r2_kind;
    logic signed [27:0] r2_prod;
    logic [HM1_W-1:0]   r2_hm1;
    logic signed [16:0] r2_udir;
    logic signed [19:0] r2_sum;
    logic signed [17:0] r2_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_kind   <= r1_kind;
            r2_prod   <= s1_prod;
            r2_hm1    <= s1_hm1;
            r2_udir   <= s1_udir;
            r2_sum    <= s1_sum;
            r2_corner <= s1_corner;
        end
    end

    // Velocity division.
    logic             s2_sign;
    logic [27:0]      s2_mag;
    logic [27:0]      s2_nu;
    logic [NUM_W-1:0] s2_num;
    logic [DEN_W-1:0] s2_den;
    logic             s2_ovf;
    t_side1           s2_side;

    always_comb begin
        s2_sign = r2_prod[27];
        s2_mag  = s2_sign ? 28'(-r2_prod) : 28'(r2_prod);
        s2_nu   = s2_mag + {19'd0, r2_hm1[HM1_W-1:1]};
        s2_num  = {6'd0, s2_nu};
        s2_den  = {6'd0, r2_hm1};
        s2_ovf  = s2_num >= {1'b0, s2_den, 17'd0};
        s2_side.valid  = r2_valid;
        s2_side.kind   = r2_kind;
        s2_side.sign   = s2_sign;
        s2_side.ovf    = s2_ovf;
        s2_side.udir   = r2_udir;
        s2_side.sum    = r2_sum;
        s2_side.corner = r2_corner;
    end

    logic [Q_BITS-1:0] div1_q;
    t_side1            r_d1 [Q_BITS];

    lbmv_div u_div_vel (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (s2_num),
        .i_den (s2_den),
        .o_quo (div1_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_BITS; k++) begin
                r_d1[k].valid <= 1'b0;
            end
        end else if (adv) begin
            r_d1[0] <= s2_side;
            for (int k = 1; k < Q_BITS; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // Velocity saturation.
    t_side1             d1;
    t_sat               s3_u;
    logic signed [17:0] s3_q;

    always_comb begin
        d1   = r_d1[Q_BITS-1];
        s3_q = d1.sign ? -$signed({1'b0, div1_q}) : $signed({1'b0, div1_q});
        if (d1.kind == K_EAST || d1.kind == K_WEST) begin
            if (d1.ovf) begin
                s3_u.flag = 1'b1;
                s3_u.val  = d1.sign ? 16'h8000 : 16'h7FFF;
            end else begin
                s3_u = sat16(s3_q);
            end
        end else begin
            s3_u = sat16({d1.udir[16], d1.udir});
        end
    end

    logic               r3_valid;
    logic [2:0]         r3_kind;
    logic [15:0]        r3_u;
    logic               r3_flag;
    logic signed [19:0] r3_sum;
    logic signed [17:0] r3_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= d1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_kind   <= d1.kind;
            r3_u      <= s3_u.val;
            r3_flag   <= s3_u.flag;
            r3_sum    <= d1.sum;
            r3_corner <= d1.corner;
        end
    end

    // Density division.
    logic signed [17:0] s4_den;
    logic               s4_bad;
    logic [DEN_W-1:0]   s4_d;
    logic               s4_sign;
    logic [19:0]        s4_mag;
    logic [NUM_W-1:0]   s4_num;
    logic               s4_ovf;
    t_side2             s4_side;

    always_comb begin
        case (r3_kind)
            K_EAST:  s4_den = 18'sd16384 + {{2{r3_u[15]}}, r3_u};
            K_WEST:  s4_den = 18'sd16384 - {{2{r3_u[15]}}, r3_u};
            default: s4_den = 18'sd16384;
        endcase
        s4_bad  = s4_den[17] || (s4_den == 18'sd0);
        s4_d    = s4_bad ? 16'd1 : s4_den[15:0];
        s4_sign = r3_sum[19];
        s4_mag  = s4_sign ? 20'(-r3_sum) : 20'(r3_sum);
        s4_num  = {s4_mag, 14'd0} + {19'd0, s4_d[DEN_W-1:1]};
        s4_ovf  = s4_num >= {1'b0, s4_d, 17'd0};
        s4_side.valid   = r3_valid;
        s4_side.kind    = r3_kind;
        s4_side.sign    = s4_sign;
        s4_side.ovf     = s4_ovf;
        s4_side.den_bad = s4_bad;
        s4_side.u       = r3_u;
        s4_side.flag    = r3_flag;
        s4_side.corner  = r3_corner;
    end

    logic [Q_BITS-1:0] div2_q;
    t_side2            r_d2 [Q_BITS];

    lbmv_div u_div_rho (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (s4_num),
        .i_den (s4_d),
        .o_quo (div2_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Q_BITS; k++) begin
                r_d2[k].valid <= 1'b0;
            end
        end else if (adv) begin
            r_d2[0] <= s4_side;
            for (int k = 1; k < Q_BITS; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // Density saturation and output register.
    t_side2             d2;
    t_sat               s5_rho;
    logic signed [17:0] s5_q;

    always_comb begin
        d2   = r_d2[Q_BITS-1];
        s5_q = d2.sign ? -$signed({1'b0, div2_q}) : $signed({1'b0, div2_q});
        if (d2.kind[2]) begin
            s5_rho = sat16(d2.corner);
        end else if (d2.den_bad) begin
            s5_rho.flag = 1'b1;
            s5_rho.val  = 16'd0;
        end else if (d2.ovf) begin
            s5_rho.flag = 1'b1;
            s5_rho.val  = d2.sign ? 16'h8000 : 16'h7FFF;
        end else begin
            s5_rho = sat16(s5_q);
        end
    end

    logic        r_out_valid;
    logic [15:0] r_out_u;
    logic [15:0] r_out_rho;
    logic        r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_u    <= d2.u;
            r_out_rho  <= s5_rho.val;
            r_out_flag <= s5_rho.flag | d2.flag;
        end
    end

    assign adv          = !(r_out_valid && i_stall);
    assign o_stall      = !adv;
    assign o_valid      = r_out_valid;
    assign o_velocity_x = r_out_u;
    assign o_velocity_y = 16'sd0;
    assign o_density    = r_out_rho;
    assign o_range_flag = r_out_flag;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");
    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_d2[Q_BITS-1].valid) && $stable(r3_valid)))
        else $error("Pipeline moved while the output was stalled.");
    a_bad_den_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && d2.valid && !d2.kind[2] && d2.den_bad) |=> (o_range_flag && o_density == 16'sd0))
        else $error("Non-positive divisor did not flag a zero density.");
`endif

endmodule
`default_nettype wire

### tb/lattice_boundary_macro_values_top_tb.sv
// Self-checking testbench for the D2Q9 boundary density and velocity block.
`timescale 1ns / 1ps
module lattice_boundary_macro_values_top_tb;
    import lbmv_pkg::*;

    typedef struct {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] dens;
        logic               flag;
    } node_result_t;

    typedef struct {
        bit                 is_cfg;
        logic               cfg_index;
        logic [15:0]        cfg_data;
        logic [2:0]         kind;
        logic [9:0]         row;
        logic signed [15:0] slots [9];
        bit                 typed;
        node_result_t       res;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic [2:0]         i_req_type = '0;
    logic [9:0]         i_row_index = '0;
    logic signed [15:0] i_slot [9] = '{default: '0};
    logic               i_stall = 1'b0;
    logic               o_cfg_ready, o_stall, o_valid, o_range_flag;
    logic signed [15:0] o_velocity_x, o_velocity_y, o_density;

    logic signed [15:0] ref_vel = 16'sd1638;
    logic [10:0]        height = 11'd256;
    node_result_t       pending_results [$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    lattice_boundary_macro_values_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_row_index(i_row_index),
        .i_slot_0(i_slot[0]), .i_slot_1(i_slot[1]), .i_slot_2(i_slot[2]),
        .i_slot_3(i_slot[3]), .i_slot_4(i_slot[4]), .i_slot_5(i_slot[5]),
        .i_slot_6(i_slot[6]), .i_slot_7(i_slot[7]), .i_slot_8(i_slot[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_velocity_x(o_velocity_x), .o_velocity_y(o_velocity_y),
        .o_density(o_density), .o_range_flag(o_range_flag)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp16(longint v, ref logic flag);
        if (v > 32767) begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic node_result_t boundary_values(logic [2:0] kind, logic [9:0] row,
                                                     logic signed [15:0] f [9]);
        node_result_t r;
        longint one, h, u, total, den, rho;
        logic flag;
        one = longint'(1) << FRAC_BITS;
        h = height;
        flag = 1'b0;
        den = one;
        if (h < 2) h = 2;
        if (h > MAX_ROWS) h = MAX_ROWS;
        if (kind == K_EAST || kind == K_WEST)
            u = round_div(longint'(ref_vel) * (2 * longint'(row) - (h - 1)), h - 1);
        else if (kind == K_NORTH || kind == K_NE || kind == K_NW)
            u = ref_vel;
        else
            u = -longint'(ref_vel);
        u = clamp16(u, flag);
        case (kind)
            K_EAST: begin
                total = f[0] + f[2] + f[4] + 2 * (longint'(f[1]) + f[5] + f[8]);
                den = one + u;
            end
            K_NORTH: total = f[0] + f[1] + f[3] + 2 * (longint'(f[2]) + f[5] + f[6]);
            K_WEST: begin
                total = f[0] + f[2] + f[4] + 2 * (longint'(f[3]) + f[6] + f[7]);
                den = one - u;
            end
            K_SOUTH: total = f[0] + f[1] + f[3] + 2 * (longint'(f[4]) + f[7] + f[8]);
            default: total = 0;
        endcase
        if (kind inside {K_NE, K_NW, K_SW, K_SE}) begin
            rho = clamp16(longint'(f[0]) + f[1] - f[2], flag);
        end else if (den <= 0) begin
            flag = 1'b1;
            rho = 0;
        end else begin
            rho = clamp16(round_div(total * one, den), flag);
        end
        r.vel_x = u[15:0];
        r.vel_y = '0;
        r.dens = rho[15:0];
        r.flag = flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        node_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result vx=%0d vy=%0d rho=%0d flag=%0b", $time,
                         o_velocity_x, o_velocity_y, o_density, o_range_flag);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_velocity_x !== want.vel_x) begin
                    $display("%0t: velocity_x expected %0d got %0d", $time,
                             want.vel_x, o_velocity_x);
                    error_count++;
                end
                if (o_velocity_y !== want.vel_y) begin
                    $display("%0t: velocity_y expected %0d got %0d", $time,
                             want.vel_y, o_velocity_y);
                    error_count++;
                end
                if (o_density !== want.dens) begin
                    $display("%0t: density expected %0d got %0d", $time,
                             want.dens, o_density);
                    error_count++;
                end
                if (o_range_flag !== want.flag) begin
                    $display("%0t: range_flag expected %0b got %0b", $time,
                             want.flag, o_range_flag);
                    error_count++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == REG_REF_VEL)
            ref_vel = data;
        else
            height = data[10:0];
    endtask

    task automatic send_node(logic [2:0] kind, logic [9:0] row, logic signed [15:0] f [9],
                             bit typed, node_result_t typed_res);
        int gap;
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_row_index <= row;
        for (int k = 0; k < 9; k++) i_slot[k] <= f[k];
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(typed ? typed_res : boundary_values(kind, row, f));
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] random_slot();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(2400, 1200));
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(20000));
        endcase
    endfunction

    function automatic logic [15:0] random_ref_vel();
        case ($urandom_range(4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(4000)) - 16'd2000;
        endcase
    endfunction

    function automatic logic [15:0] random_height();
        case ($urandom_range(4))
            0: return 16'($urandom_range(3));
            1: return $urandom_range(1) ? 16'd1024 : 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(300, 2));
        endcase
    endfunction

    function automatic stim_row_t node_row(logic [2:0] kind, logic [9:0] row,
                                           logic signed [15:0] fill, bit typed,
                                           logic signed [15:0] vx, logic signed [15:0] rho,
                                           logic flag);
        stim_row_t s;
        s.is_cfg = 1'b0;
        s.cfg_index = 1'b0;
        s.cfg_data = '0;
        s.kind = kind;
        s.row = row;
        s.slots = '{default: fill};
        s.typed = typed;
        s.res = '{vel_x: vx, vel_y: 16'sd0, dens: rho, flag: flag};
        return s;
    endfunction

    function automatic stim_row_t cfg_row(logic index, logic [15:0] data);
        stim_row_t s;
        s = node_row(K_EAST, '0, '0, 1'b0, '0, '0, 1'b0);
        s.is_cfg = 1'b1;
        s.cfg_index = index;
        s.cfg_data = data;
        return s;
    endfunction

    initial begin
        stim_row_t directed [$];
        stim_row_t s;
        logic signed [15:0] f [9];
        node_result_t none;

        none = '{vel_x: '0, vel_y: '0, dens: '0, flag: 1'b0};
        directed.push_back(node_row(K_EAST, 10'd0, 16'sd0, 1, -16'sd1638, 16'sd0, 0));
        directed.push_back(node_row(K_NORTH, 10'd7, 16'sd0, 1, 16'sd1638, 16'sd0, 0));
        directed.push_back(node_row(K_WEST, 10'd255, 16'sd0, 1, 16'sd1638, 16'sd0, 0));
        directed.push_back(node_row(K_SOUTH, 10'd3, 16'sd0, 1, -16'sd1638, 16'sd0, 0));
        s = node_row(K_NE, 10'd0, 16'sd0, 1, 16'sd1638, 16'sh7FFF, 1);
        s.slots[0] = 16'sh7FFF;
        s.slots[1] = 16'sh7FFF;
        s.slots[2] = 16'sh8000;
        directed.push_back(s);
        s = node_row(K_NW, 10'h3FF, 16'sd0, 1, 16'sd1638, 16'sh8000, 1);
        s.slots[0] = 16'sh8000;
        s.slots[1] = 16'sh8000;
        s.slots[2] = 16'sh7FFF;
        directed.push_back(s);
        s = node_row(K_SW, 10'd1, 16'sh5555, 1, -16'sd1638, 16'sd0, 0);
        s.slots[0] = 16'sd1;
        s.slots[1] = 16'sd2;
        s.slots[2] = 16'sd3;
        directed.push_back(s);
        directed.push_back(node_row(K_SE, 10'd0, 16'sh7FFF, 0, '0, '0, 0));
        directed.push_back(node_row(K_EAST, 10'h3FF, 16'sh7FFF, 0, '0, '0, 0));
        directed.push_back(node_row(K_WEST, 10'h3FF, 16'sh8000, 0, '0, '0, 0));
        directed.push_back(node_row(K_NORTH, 10'h2AA, 16'sh7FFF, 0, '0, '0, 0));
        directed.push_back(node_row(K_SOUTH, 10'h155, 16'sh8000, 0, '0, '0, 0));
        directed.push_back(node_row(K_EAST, 10'd128, 16'sd1820, 0, '0, '0, 0));
        directed.push_back(cfg_row(REG_REF_VEL, 16'h7FFF));
        directed.push_back(cfg_row(REG_HEIGHT, 16'd2));
        directed.push_back(node_row(K_EAST, 10'd0, 16'sd0, 1, -16'sd32767, 16'sd0, 1));
        directed.push_back(node_row(K_WEST, 10'd1, 16'sd0, 1, 16'sd32767, 16'sd0, 1));
        directed.push_back(node_row(K_EAST, 10'h3FF, 16'sd100, 0, '0, '0, 0));
        directed.push_back(cfg_row(REG_REF_VEL, 16'h8000));
        directed.push_back(cfg_row(REG_HEIGHT, 16'd0));
        directed.push_back(node_row(K_WEST, 10'd0, 16'sd0, 1, 16'sh7FFF, 16'sd0, 1));
        directed.push_back(node_row(K_NORTH, 10'd0, 16'sd0, 1, 16'sh8000, 16'sd0, 0));
        directed.push_back(node_row(K_SOUTH, 10'd0, 16'sd0, 1, 16'sh7FFF, 16'sd0, 1));
        directed.push_back(cfg_row(REG_HEIGHT, 16'hFFFF));
        directed.push_back(node_row(K_EAST, 10'd512, 16'sd1820, 0, '0, '0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct = 48;
        foreach (directed[n]) begin
            if (directed[n].is_cfg) begin
                i_valid <= 1'b0;
                drain();
                write_register(directed[n].cfg_index, directed[n].cfg_data);
            end else begin
                send_node(directed[n].kind, directed[n].row, directed[n].slots,
                          directed[n].typed, directed[n].res);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 13 : 0;
            for (int part = 0; part < 4; part++) begin
                i_valid <= 1'b0;
                drain();
                write_register(REG_REF_VEL, random_ref_vel());
                write_register(REG_HEIGHT, random_height());
                for (int n = 0; n < 50; n++) begin
                    for (int k = 0; k < 9; k++) f[k] = random_slot();
                    send_node(3'($urandom_range(7)), 10'($urandom), f, 1'b0, none);
                end
            end
        end

        i_valid <= 1'b0;
        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
